### src/jps_pkg.sv
// Shared constants and register codes for the Jacobi stencil sweep block.
package jps_pkg;

  localparam int GRID_MAX_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 32;

  localparam int GRID_SIZE_W = 11;
  localparam int STEP_W      = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 11'd1024;
  localparam logic [STEP_W-1:0]      STEP_SQ_RST   = 32'd4100;

  // h^2 is Q0.32 and f is Q16.16, so the product carries 48 fraction bits.
  // Shifting by this amount leaves Q.18, which lines up with 4 * neighbor sum.
  localparam int PROD_SHIFT = 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_SIZE      = 2'd0,
    REG_STEP_SQUARED   = 2'd1,
    REG_BOUNDARY_VALUE = 2'd2
  } cfg_reg_t;

endpackage

### src/jps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module jps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/jacobi_poisson_stencil_sweep.sv
// Streaming Jacobi sweep of the 2D Poisson equation with a 5-point stencil.
//
//   channel  direction  handshake          payload
//   in_      input      valid / ready      old_value, rhs_value
//   out_     output     valid / ready      new_value, is_border, saturated,
//                                          frame_end, run_last
//   cfg_     input      write enable only  index, data
//
// One item is taken per cycle while the output does not stall; an item of the last grid
// row yields two results, so that row is held back by the single output register.
// An input transfer reaches the output through the operand/product register and then
// the result register. Row 0 yields no results.
// Reset is synchronous and active low; the row stores are not cleared.
// A stalled output holds its result while one more item waits in the operand stage.
module jacobi_poisson_stencil_sweep
  import jps_pkg::*;
#(
  parameter int GRID_MAX   = GRID_MAX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_BITS-1:0]  in_old_value,
  input  logic [VALUE_BITS-1:0]  in_rhs_value,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_BITS-1:0]  out_new_value,
  output logic                   out_is_border,
  output logic                   out_saturated,
  output logic                   out_frame_end,
  output logic                   out_run_last,

  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [((VALUE_BITS > STEP_W) ? VALUE_BITS : STEP_W)-1:0] cfg_data
);

  localparam int AW    = $clog2(GRID_MAX);
  localparam int CW    = $clog2(GRID_MAX + 1);
  localparam int PW    = VALUE_BITS + STEP_W + 1;
  localparam int NW    = VALUE_BITS + 2;
  localparam int ACC_W = VALUE_BITS + 5;

  // Configuration registers
  logic [GRID_SIZE_W-1:0] grid_size_r;
  logic [STEP_W-1:0]      step_sq_r;
  logic [VALUE_BITS-1:0]  boundary_r;

  // Raster position of the next input item
  logic [AW-1:0] row_r, row_nxt;
  logic [AW-1:0] col_r, col_nxt;

  // Row r-1 values at the current column and at the previous column
  logic [VALUE_BITS-1:0] prior_here_r;
  logic [VALUE_BITS-1:0] left_hold_r;

  // Operand/product stage
  logic                  s1_valid_r;
  logic signed [PW-1:0]  s1_prod_r;
  logic signed [NW-1:0]  s1_nsum_r;
  logic                  s1_border_r;
  logic                  s1_last_row_r;
  logic                  s1_last_col_r;

  // Result stage; dbl_r marks the trailing border result of the last row
  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_border_r;
  logic                  out_sat_r;
  logic                  out_fend_r;
  logic                  out_last_r;
  logic                  dbl_r;
  logic                  dbl_fend_r;

  logic [CW-1:0] n_eff;
  logic          last_col, last_row;
  logic          in_fire, out_fire, out_take, s1_go;
  logic          grid_wr;

  logic [AW-1:0]         prior_raddr, cur_raddr;
  logic [VALUE_BITS-1:0] older_rd, prior_rd, rhs_rd;

  logic signed [PW-1:0]    prod_nxt;
  logic signed [NW-1:0]    nsum_nxt;
  logic signed [ACC_W-1:0] acc;
  logic signed [VALUE_BITS:0] res;
  logic [VALUE_BITS-1:0]   clip_value;
  logic                    clip_sat;

  // Effective grid size, clamped to [3, GRID_MAX]
  always_comb begin
    logic [31:0] gs;
    gs = 32'(grid_size_r);
    if (gs < 32'd3) begin
      n_eff = CW'(3);
    end else if (gs > 32'(GRID_MAX)) begin
      n_eff = CW'(GRID_MAX);
    end else begin
      n_eff = CW'(gs);
    end
  end

  assign last_col = (col_r == AW'(n_eff - CW'(1)));
  assign last_row = (row_r == AW'(n_eff - CW'(1)));
  assign grid_wr  = cfg_we && (cfg_index == REG_GRID_SIZE);

  assign out_take = !out_valid_r || (out_ready && !dbl_r);
  assign s1_go    = s1_valid_r && out_take;
  assign in_ready = !s1_valid_r || out_take;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // Position update
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (grid_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  // Reads target the next position so data is ready when that item arrives.
  // The prior row is fetched one column ahead to supply the right neighbor.
  assign cur_raddr   = col_nxt;
  assign prior_raddr = (col_nxt == AW'(n_eff - CW'(1))) ? '0 : col_nxt + AW'(1);

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_MAX)) u_older_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (prior_here_r),
    .raddr (cur_raddr),
    .rdata (older_rd)
  );

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_MAX)) u_prior_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (in_old_value),
    .raddr (prior_raddr),
    .rdata (prior_rd)
  );

  jps_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_MAX)) u_rhs_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (in_rhs_value),
    .raddr (cur_raddr),
    .rdata (rhs_rd)
  );

  // Stage 1 operands: f*h^2 and the neighbor sum
  always_comb begin
    prod_nxt = PW'($signed(rhs_rd)) * PW'($signed({1'b0, step_sq_r}));
    nsum_nxt = NW'($signed(older_rd)) + NW'($signed(in_old_value))
             + NW'($signed(left_hold_r)) + NW'($signed(prior_rd));
  end

  // Stage 2: floor((f*h^2 + sum) / 4), then clip
  always_comb begin
    acc = {{2{s1_prod_r[PW-1]}}, s1_prod_r[PW-1:PROD_SHIFT]}
        + {s1_nsum_r[NW-1], s1_nsum_r, 2'b00};
    res = acc[ACC_W-1:4];
    clip_sat = (res[VALUE_BITS] != res[VALUE_BITS-1]);
    if (clip_sat) begin
      clip_value = res[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                   : {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      clip_value = res[VALUE_BITS-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
      step_sq_r   <= STEP_SQ_RST;
      boundary_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      dbl_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SIZE:      grid_size_r <= cfg_data[GRID_SIZE_W-1:0];
          REG_STEP_SQUARED:   step_sq_r   <= cfg_data[STEP_W-1:0];
          REG_BOUNDARY_VALUE: boundary_r  <= cfg_data[VALUE_BITS-1:0];
          default: ;
        endcase
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (in_fire) begin
        s1_valid_r <= (row_r != '0);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
        dbl_r       <= s1_last_row_r;
      end else if (out_fire) begin
        out_valid_r <= dbl_r;
        dbl_r       <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prior_here_r  <= prior_rd;
      left_hold_r   <= prior_here_r;
      s1_prod_r     <= prod_nxt;
      s1_nsum_r     <= nsum_nxt;
      s1_border_r   <= (row_r == AW'(1)) || (col_r == '0) || last_col;
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
    end
    if (s1_go) begin
      out_value_r  <= s1_border_r ? boundary_r : clip_value;
      out_border_r <= s1_border_r;
      out_sat_r    <= !s1_border_r && clip_sat;
      out_fend_r   <= 1'b0;
      out_last_r   <= !s1_last_row_r;
      dbl_fend_r   <= s1_last_col_r;
    end else if (out_fire && dbl_r) begin
      // Trailing result: the last grid row itself, always on the border.
      out_value_r  <= boundary_r;
      out_border_r <= 1'b1;
      out_sat_r    <= 1'b0;
      out_fend_r   <= dbl_fend_r;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_is_border = out_border_r;
  assign out_saturated = out_sat_r;
  assign out_frame_end = out_fend_r;
  assign out_run_last  = out_last_r;

  a_dbl_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    dbl_r |-> out_valid_r)
    else $error("trailing result pending without a valid result");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_take) |=> s1_valid_r)
    else $error("operand stage dropped an item while stalled");

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < 32'(n_eff)) && (32'(row_r) < 32'(n_eff)))
    else $error("raster position outside the grid");

  a_fend_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fend_r) |-> (out_border_r && out_last_r && !dbl_r))
    else $error("frame end on a non-final result");

  a_sat_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> !out_border_r)
    else $error("saturation flagged on a border result");

endmodule
